FILE: sv/ebwd_pkg.sv
// ----------------------------------------------------------------------------
// ebwd_pkg
// Shared constants and types for the event burst window detector.
// ----------------------------------------------------------------------------
package ebwd_pkg;

  localparam int unsigned WINDOW_EVENTS = 16;
  localparam int unsigned SLOT_W        = (WINDOW_EVENTS > 1) ? $clog2(WINDOW_EVENTS) : 1;
  localparam int unsigned CNT_W         = $clog2(WINDOW_EVENTS + 1);

  localparam int unsigned STAMP_W = 64;
  localparam int unsigned HELD_W  = 5;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_EVENTS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_EVENTS);
  localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(WINDOW_EVENTS);

  // Read side of the ring, registered on each push
  typedef struct packed {
    logic [STAMP_W-1:0] first;
    logic [STAMP_W-1:0] now;
    logic [CNT_W-1:0]   held;
    logic               full;
  } ring_rd_t;

  function automatic logic [SLOT_W-1:0] slot_adv(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] nxt;
    nxt = (slot == SLOT_LAST) ? '0 : slot + SLOT_W'(1);
    return nxt;
  endfunction

endpackage

FILE: sv/event_burst_window_detector.sv
// ----------------------------------------------------------------------------
// event_burst_window_detector
// Keeps the last WINDOW_EVENTS event timestamps in a ring and flags bursts
// whose span over a full window is at or below a programmed threshold.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (LSB first)
//  s_axis    in         event_time[63:0]
//  m_axis    out        too_fast, window_full, window_span[63:0], events_held[4:0]
//  cfg       in         span_threshold[63:0] (write only)
//
//  One transaction per cycle sustained unless the output stalls. Stages:
//  ring read register, then subtract and compare into the output register.
//  The ring memory port pair sets the rate: one write and one read per event.
//  Reset clears slot pointers, fill count, threshold and valid flags.
//  A stalled output holds its register; input stays ready while the pipe
//  can advance.
// ----------------------------------------------------------------------------
module event_burst_window_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [ebwd_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,   // event_time[63:0]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // too_fast[0], window_full[1], window_span[65:2], events_held[70:66], zero[71]
  output logic [ebwd_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [ebwd_pkg::STAMP_W-1:0]      cfg_wdata_i
);
  import ebwd_pkg::*;

  logic               accept;
  logic               s1_valid_q;
  logic               s1_adv;
  ring_rd_t           ring_rd;
  logic [STAMP_W-1:0] threshold_q;
  logic [STAMP_W-1:0] span;
  logic               too_fast;

  logic               out_valid_q;
  logic               out_fast_q;
  logic               out_full_q;
  logic [STAMP_W-1:0] out_span_q;
  logic [HELD_W-1:0]  out_held_q;

  assign s1_adv          = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  ebwd_ring u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .event_time_i (s_axis_tdata_i[STAMP_W-1:0]),
    .rd_o         (ring_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  assign span     = ring_rd.now - ring_rd.first;
  assign too_fast = ring_rd.full && (span <= threshold_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_fast_q <= too_fast;
      out_full_q <= ring_rd.full;
      out_span_q <= span;
      out_held_q <= HELD_W'(ring_rd.held);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_held_q, out_span_q, out_full_q, out_fast_q};

endmodule

FILE: sv/ebwd_ring.sv
// ----------------------------------------------------------------------------
// ebwd_ring
// Timestamp ring: slot pointers, fill count and a synchronous memory with a
// registered read of the oldest entry. Same-slot read and write forwards.
// ----------------------------------------------------------------------------
module ebwd_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [ebwd_pkg::STAMP_W-1:0]  event_time_i,
  output ebwd_pkg::ring_rd_t            rd_o
);
  import ebwd_pkg::*;

  logic [STAMP_W-1:0] mem [WINDOW_EVENTS];

  logic [SLOT_W-1:0]  oldest_q, oldest_d;
  logic [SLOT_W-1:0]  next_q, next_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               drop;

  logic [STAMP_W-1:0] rd_data_q;
  logic [STAMP_W-1:0] now_q;
  logic               fwd_q;
  logic [CNT_W-1:0]   held_q;
  logic               full_q;

  always_comb begin
    drop     = (count_q == CNT_FULL);
    oldest_d = drop ? slot_adv(oldest_q) : oldest_q;
    next_d   = slot_adv(next_q);
    count_d  = drop ? count_q : count_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      next_q   <= '0;
      count_q  <= '0;
    end else if (push_i) begin
      oldest_q <= oldest_d;
      next_q   <= next_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[next_q] <= event_time_i;
      rd_data_q   <= mem[oldest_d];
      now_q       <= event_time_i;
      fwd_q       <= (oldest_d == next_q);
      held_q      <= count_d;
      full_q      <= (count_d == CNT_FULL);
    end
  end

  assign rd_o.first = fwd_q ? now_q : rd_data_q;
  assign rd_o.now   = now_q;
  assign rd_o.held  = held_q;
  assign rd_o.full  = full_q;

endmodule

FILE: sv/ebwd_checker.sv
// ----------------------------------------------------------------------------
// ebwd_checker
// Port-level checks for the event burst window detector, bound to the top.
// ----------------------------------------------------------------------------
module ebwd_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic [ebwd_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [ebwd_pkg::STAMP_W-1:0]      cfg_wdata_i
);
  import ebwd_pkg::*;

  logic [STAMP_W-1:0] thr_q;
  logic               o_fast;
  logic               o_full;
  logic [STAMP_W-1:0] o_span;
  logic [HELD_W-1:0]  o_held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign o_fast = m_axis_tdata_o[0];
  assign o_full = m_axis_tdata_o[1];
  assign o_span = m_axis_tdata_o[STAMP_W+1:2];
  assign o_held = m_axis_tdata_o[STAMP_W+HELD_W+1:STAMP_W+2];

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

  a_fast_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (o_fast == (o_full && (o_span <= thr_q))))
    else $error("too_fast disagrees with span and threshold");

  a_full_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && o_full |-> (o_held == HELD_FULL))
    else $error("full window with wrong event count");

endmodule

bind event_burst_window_detector ebwd_checker u_ebwd_checker (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the event burst window detector. Streams event
// timestamps through the slave side, predicts span, fill and burst flag from
// its own copy of the ring, and compares each master-side transaction in
// order. A short directed table opens the run; random phases with several
// threshold settings follow, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import ebwd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned PHASE_COUNT  = 5;
  localparam int unsigned PRESSURE_AT  = 300;
  localparam int unsigned PRESSURE_LEN = 80;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  typedef struct packed {
    logic               too_fast;
    logic               window_full;
    logic [STAMP_W-1:0] window_span;
    logic [HELD_W-1:0]  events_held;
  } burst_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [7:0]         reps;
    logic               typed;
    burst_t             want;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 11;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{STAMP_MAX, 8'd1, 1'b1, '{1'b0, 1'b0, 64'd0, 5'd1}},
    '{STAMP_MAX, 8'd14, 1'b0, '0},
    '{STAMP_MAX, 8'd1, 1'b1, '{1'b1, 1'b1, 64'd0, 5'd16}},
    '{64'd0, 8'd1, 1'b1, '{1'b0, 1'b1, 64'd1, 5'd16}},
    '{64'h8000_0000_0000_0000, 8'd1, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 8'd1, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 8'd1, 1'b0, '0},
    '{64'd3, 8'd1, 1'b0, '0},
    '{64'd2, 8'd1, 1'b0, '0},
    '{64'h0000_0001_0000_0000, 8'd1, 1'b0, '0},
    '{64'h0000_0001_0000_0000, 8'd1, 1'b0, '0}
  };

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [STAMP_W-1:0]    cfg_wdata = '0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  logic [STAMP_W-1:0] ring_copy [WINDOW_EVENTS];
  int unsigned        oldest_idx   = 0;
  int unsigned        next_idx     = 0;
  int unsigned        held_count   = 0;
  logic [STAMP_W-1:0] thresh_copy  = '0;
  logic [STAMP_W-1:0] cur_stamp    = '0;
  int unsigned        sender_calm  = 0;
  int unsigned        cycle_count  = 0;
  int unsigned        results_seen = 0;
  int unsigned        mismatch_count = 0;
  burst_t             pending_bursts [$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  event_burst_window_detector i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  function automatic burst_t window_predict(input logic [STAMP_W-1:0] now);
    burst_t             res;
    logic [STAMP_W-1:0] first;
    if (held_count >= WINDOW_EVENTS) begin
      oldest_idx = (oldest_idx + 1) % WINDOW_EVENTS;
      held_count = WINDOW_EVENTS - 1;
    end
    ring_copy[next_idx] = now;
    next_idx = (next_idx + 1) % WINDOW_EVENTS;
    held_count++;
    first = ring_copy[oldest_idx];
    res.window_span = now - first;
    res.window_full = (held_count == WINDOW_EVENTS);
    res.too_fast    = res.window_full && (res.window_span <= thresh_copy);
    res.events_held = HELD_W'(held_count);
    return res;
  endfunction

  function automatic logic [STAMP_W-1:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      cur_stamp = cur_stamp;
    end else if (pick < 75) begin
      cur_stamp = cur_stamp + STAMP_W'($urandom_range(1, 40));
    end else if (pick < 88) begin
      cur_stamp = cur_stamp + STAMP_W'($urandom);
    end else if (pick < 94) begin
      cur_stamp = cur_stamp - STAMP_W'($urandom_range(1, 1000));
    end else begin
      cur_stamp = {$urandom, $urandom};
    end
    return cur_stamp;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (sender_calm > 0) begin
      sender_calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      sender_calm = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_event(input logic [STAMP_W-1:0] stamp, input logic typed,
                            input burst_t want);
    int unsigned gap;
    burst_t      predicted;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= stamp;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = window_predict(stamp);
    pending_bursts.push_back(typed ? want : predicted);
  endtask

  task automatic set_threshold(input logic [STAMP_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_bursts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    thresh_copy = value;
  endtask

  task automatic flag_field(input string name, input logic [STAMP_W-1:0] want,
                            input logic [STAMP_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    burst_t      got;
    burst_t      want;
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned pick;
    bit          pressure_done;
    stall_left    = 0;
    calm_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_tready) begin
        got.too_fast    = m_axis_tdata_o[0];
        got.window_full = m_axis_tdata_o[1];
        got.window_span = m_axis_tdata_o[65:2];
        got.events_held = m_axis_tdata_o[70:66];
        results_seen++;
        if (pending_bursts.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction, actual %h", $time, got);
        end else begin
          want = pending_bursts.pop_front();
          flag_field("too_fast", STAMP_W'(want.too_fast), STAMP_W'(got.too_fast));
          flag_field("window_full", STAMP_W'(want.window_full), STAMP_W'(got.window_full));
          flag_field("window_span", want.window_span, got.window_span);
          flag_field("events_held", STAMP_W'(want.events_held), STAMP_W'(got.events_held));
        end
      end
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_LEN;
        calm_left     = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        m_tready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          calm_left = $urandom_range(30, 120);
          m_tready <= 1'b1;
        end else if (pick < 70) begin
          m_tready <= 1'b1;
        end else begin
          stall_left = (pick < 93) ? $urandom_range(0, 2) : $urandom_range(9, 29);
          m_tready <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic [STAMP_W-1:0] phase_thresh;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_threshold('0);
    for (int r = 0; r < DIR_ROWS; r++) begin
      repeat (DIR_TABLE[r].reps) begin
        send_event(DIR_TABLE[r].stamp, DIR_TABLE[r].typed, DIR_TABLE[r].want);
      end
    end
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       phase_thresh = STAMP_MAX;
        1:       phase_thresh = STAMP_W'($urandom_range(150, 450));
        2:       phase_thresh = '0;
        3:       phase_thresh = {$urandom, $urandom};
        default: phase_thresh = STAMP_W'($urandom_range(1, 600));
      endcase
      set_threshold(phase_thresh);
      repeat (PHASE_ITEMS) send_event(next_stamp(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    while (pending_bursts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ebwd_pkg.sv
sv/ebwd_ring.sv
sv/event_burst_window_detector.sv
sv/ebwd_checker.sv
bench/tb_top.sv
